### hw/rtl/shell_line_continuation_check_macros.svh
// assertion helpers, sampled on clk and held off during rst
`ifndef SHELL_LINE_CONTINUATION_CHECK_MACROS_SVH
`define SHELL_LINE_CONTINUATION_CHECK_MACROS_SVH

// same-cycle implication
`define SLCC_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLCC_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/slcc_pkg.sv
package slcc_pkg;

  // need and verdict codes
  localparam logic [2:0] NeedNone   = 3'd0;
  localparam logic [2:0] NeedSquote = 3'd1;
  localparam logic [2:0] NeedDquote = 3'd2;
  localparam logic [2:0] NeedParen  = 3'd3;
  localparam logic [2:0] NeedPipe   = 3'd4;
  localparam logic [2:0] NeedAnd    = 3'd5;
  localparam logic [2:0] NeedOr     = 3'd6;

  localparam logic [7:0] CharAmp    = 8'h26;
  localparam logic [7:0] CharBar    = 8'h7C;
  localparam logic [7:0] CharOpen   = 8'h28;
  localparam logic [7:0] CharClose  = 8'h29;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSpace  = 8'd32;
  localparam logic [7:0] CharTab    = 8'd9;
  localparam logic [7:0] CharCr     = 8'd13;

  localparam logic signed [15:0] DepthMax = 16'sh7FFF;
  localparam logic signed [15:0] DepthMin = 16'sh8000;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } slcc_byte_t;

  typedef struct packed {
    logic [2:0]         verdict;
    logic signed [15:0] paren_depth;
  } slcc_result_t;

endpackage

### hw/rtl/slcc_if.sv
interface slcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_end;

  modport source (output valid, output char_byte, output line_end, input ready);
  modport sink (input valid, input char_byte, input line_end, output ready);
endinterface

interface slcc_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         verdict;
  logic signed [15:0] paren_depth;

  modport source (output valid, output verdict, output paren_depth, input ready);
  modport sink (input valid, input verdict, input paren_depth, output ready);
endinterface

### hw/rtl/shell_line_continuation_check.sv
// the result register loads as a line's last byte leaves the input register
// throughput: one byte per cycle; a non-final byte never waits on the result side
// a final byte waits in the input register only while a previous result is unread
// the input register and the result register part the two sides
// reset: synchronous rst empties both registers and returns the lexer to normal mode
module shell_line_continuation_check
  import slcc_pkg::*;
(
  input logic          clk,
  input logic          rst,
  slcc_byte_if.sink    chars,
  slcc_result_if.source report
);

  logic         in_valid;
  slcc_byte_t   in_data;
  logic         out_valid;
  slcc_result_t out_data;
  slcc_result_t lex_res;
  logic         out_free;
  logic         advance;

  assign out_free    = !out_valid || report.ready;
  assign advance     = in_valid && (!in_data.line_end || out_free);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      in_data.char_byte <= chars.char_byte;
      in_data.line_end  <= chars.line_end;
    end
  end

  slcc_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cur  (in_data),
    .res  (lex_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_data.line_end) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && in_data.line_end) begin
      out_data <= lex_res;
    end
  end

  assign report.valid       = out_valid;
  assign report.verdict     = out_data.verdict;
  assign report.paren_depth = out_data.paren_depth;

`include "shell_line_continuation_check_macros.svh"

  `SLCC_NEXT(a_result_loads, advance && in_data.line_end, out_valid, "final byte left no result")
  `SLCC_IMPLY(a_empty_takes, !in_valid, chars.ready, "empty input register refused a beat")
  `SLCC_IMPLY(a_paren_depth, out_valid && out_data.verdict == NeedParen, out_data.paren_depth > 16'sd0, "paren verdict without open depth")

endmodule

### hw/rtl/slcc_lexer.sv
module slcc_lexer
  import slcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  slcc_byte_t   cur,
  output slcc_result_t res
);

  typedef enum logic [2:0] {
    ModeNormal,
    ModeSquote,
    ModeDquote,
    ModeAmp,
    ModePipe
  } mode_t;

  mode_t              mode;
  mode_t              mode_next;
  logic [2:0]         need;
  logic [2:0]         need_next;
  logic signed [15:0] depth;
  logic signed [15:0] depth_next;
  logic [2:0]         final_need;
  logic               as_normal;
  logic               blank;
  logic [7:0]         c;

  assign c     = cur.char_byte;
  assign blank = (c == CharSpace) || (c inside {[CharTab:CharCr]});

  always_comb begin
    mode_next  = mode;
    need_next  = need;
    depth_next = depth;
    as_normal  = 1'b0;
    case (mode)
      ModeSquote: begin
        if (c == CharSquote) begin
          need_next = NeedNone;
          mode_next = ModeNormal;
        end
      end
      ModeDquote: begin
        if (c == CharDquote) begin
          need_next = NeedNone;
          mode_next = ModeNormal;
        end
      end
      ModeAmp: begin
        mode_next = ModeNormal;
        if (c == CharAmp) begin
          need_next = NeedAnd;
        end else begin
          need_next = NeedNone;
          as_normal = 1'b1;
        end
      end
      ModePipe: begin
        mode_next = ModeNormal;
        if (c == CharBar) begin
          need_next = NeedOr;
        end else begin
          need_next = NeedPipe;
          as_normal = 1'b1;
        end
      end
      default: begin
        mode_next = ModeNormal;
        as_normal = 1'b1;
      end
    endcase

    if (as_normal) begin
      if (c == CharAmp) begin
        mode_next = ModeAmp;
      end else if (c == CharBar) begin
        mode_next = ModePipe;
      end else if (c == CharOpen) begin
        if (depth != DepthMax) depth_next = depth + 16'sd1;
      end else if (c == CharClose) begin
        if (depth != DepthMin) depth_next = depth - 16'sd1;
      end else if (c == CharSquote) begin
        need_next = NeedSquote;
        mode_next = ModeSquote;
      end else if (c == CharDquote) begin
        need_next = NeedDquote;
        mode_next = ModeDquote;
      end else if (!blank) begin
        need_next = NeedNone;
      end
    end
  end

  // a lone '&' or '|' left at line end settles here
  always_comb begin
    case (mode_next)
      ModeAmp:  final_need = NeedNone;
      ModePipe: final_need = NeedPipe;
      default:  final_need = need_next;
    endcase
    res.paren_depth = depth_next;
    if (final_need == NeedNone && depth_next > 16'sd0) begin
      res.verdict = NeedParen;
    end else begin
      res.verdict = final_need;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= ModeNormal;
      need  <= NeedNone;
      depth <= '0;
    end else if (step) begin
      if (cur.line_end) begin
        mode  <= ModeNormal;
        need  <= NeedNone;
        depth <= '0;
      end else begin
        mode  <= mode_next;
        need  <= need_next;
        depth <= depth_next;
      end
    end
  end

`include "shell_line_continuation_check_macros.svh"

  `SLCC_NEXT(a_line_clears, step && cur.line_end, mode == ModeNormal && need == NeedNone && depth == 16'sd0, "state not cleared after line end")
  `SLCC_IMPLY(a_squote_need, mode == ModeSquote, need == NeedSquote, "single quote mode without its need")
  `SLCC_IMPLY(a_dquote_need, mode == ModeDquote, need == NeedDquote, "double quote mode without its need")

endmodule
